// ----- hdl/mtep_pkg.sv -----
// Types and constants shared by the track event parser modules.
package mtep_pkg;

  // Width of every length and delta field that leaves the block.
  localparam int unsigned OUT_BITS = 28;

  // Result kinds.
  localparam logic [2:0] KIND_CHANNEL   = 3'd0;
  localparam logic [2:0] KIND_META      = 3'd1;
  localparam logic [2:0] KIND_SYSEX     = 3'd2;
  localparam logic [2:0] KIND_NO_STATUS = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED = 3'd4;

  // Status byte values and masks.
  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] HI_NIBBLE     = 8'hF0;
  localparam logic [7:0] SYSTEM_GROUP  = 8'hF0;
  localparam logic [7:0] PROGRAM_GROUP = 8'hC0;
  localparam logic [7:0] PRESSURE_GROUP = 8'hD0;

  // Data counts of channel messages.
  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_TWO  = 2'd2;

  // Where the parser stands inside the current event.
  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_MTYPE,
    PH_LEN,
    PH_SKIP
  } phase_t;

  // One input item: a raw track byte and its end-of-track mark.
  typedef struct packed {
    logic [7:0] track_byte;
    logic       last_in_track;
  } in_t;

  // One result item: a completed event or an error.
  typedef struct packed {
    logic [2:0]          event_kind;
    logic [OUT_BITS-1:0] delta_time;
    logic [7:0]          status_byte;
    logic [7:0]          meta_type;
    logic [7:0]          data_first;
    logic [7:0]          data_second;
    logic [1:0]          data_count;
    logic [OUT_BITS-1:0] payload_length;
    logic                running_status_used;
  } out_t;

endpackage

// ----- hdl/mtep_parser.sv -----
// Parser state registers and the per-byte update that builds one result.
module mtep_parser import mtep_pkg::*; #(
  parameter int unsigned VLQ_BITS = 28
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  item,
  output logic result_valid,
  output out_t result
);

  phase_t              phase, phase_next;
  logic [VLQ_BITS-1:0] delta_acc, delta_acc_next;
  logic [7:0]          running_status, running_status_next;
  logic [7:0]          current_status, current_status_next;
  logic [7:0]          meta_type_held, meta_type_held_next;
  logic [VLQ_BITS-1:0] len_acc, len_acc_next;
  logic [VLQ_BITS-1:0] skip_cnt, skip_cnt_next;
  logic [7:0]          first_data, first_data_next;
  logic                reused, reused_next;
  logic                halted, halted_next;

  logic [VLQ_BITS+6:0] delta_wide, len_wide;
  logic [VLQ_BITS-1:0] delta_push, len_push, skip_dec;
  logic [7:0]          b;
  logic                one_byte_new, one_byte_cur;

  assign b = item.track_byte;

  // A VLQ digit shifts in seven bits and keeps the low VLQ_BITS of them.
  assign delta_wide = {delta_acc, b[6:0]};
  assign len_wide   = {len_acc, b[6:0]};
  assign delta_push = delta_wide[VLQ_BITS-1:0];
  assign len_push   = len_wide[VLQ_BITS-1:0];
  assign skip_dec   = (skip_cnt != '0) ? skip_cnt - 1'b1 : skip_cnt;

  // Program change and channel pressure carry a single data byte.
  assign one_byte_new = ((running_status & HI_NIBBLE) == PROGRAM_GROUP) ||
                        ((running_status & HI_NIBBLE) == PRESSURE_GROUP);
  assign one_byte_cur = ((current_status & HI_NIBBLE) == PROGRAM_GROUP) ||
                        ((current_status & HI_NIBBLE) == PRESSURE_GROUP);

  // Next state and result for the byte at hand.
  always_comb begin
    logic [31:0] delta32, len32, delta_next32;
    logic        done;
    delta32             = 32'(delta_acc);
    len32               = 32'(len_acc);
    delta_next32        = '0;
    done                = 1'b0;
    phase_next          = phase;
    delta_acc_next      = delta_acc;
    running_status_next = running_status;
    current_status_next = current_status;
    meta_type_held_next = meta_type_held;
    len_acc_next        = len_acc;
    skip_cnt_next       = skip_cnt;
    first_data_next     = first_data;
    reused_next         = reused;
    halted_next         = halted;
    result_valid        = 1'b0;
    result              = '0;
    result.delta_time   = delta32[OUT_BITS-1:0];

    if (!halted) begin
      case (phase)
        PH_DELTA: begin
          delta_acc_next = delta_push;
          if (!b[7]) begin
            phase_next = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if ((b & HI_NIBBLE) == SYSTEM_GROUP) begin
            current_status_next = b;
            len_acc_next        = '0;
            phase_next          = (b == STATUS_META) ? PH_MTYPE : PH_LEN;
          end else if (b[7]) begin
            current_status_next = b;
            running_status_next = b;
            reused_next         = 1'b0;
            phase_next          = PH_DATA1;
          end else if (running_status[7]) begin
            current_status_next = running_status;
            reused_next         = 1'b1;
            first_data_next     = b;
            if (one_byte_new) begin
              result_valid               = 1'b1;
              result.event_kind          = KIND_CHANNEL;
              result.status_byte         = running_status;
              result.data_first          = b;
              result.data_count          = COUNT_ONE;
              result.running_status_used = 1'b1;
              done                       = 1'b1;
            end else begin
              phase_next = PH_DATA2;
            end
          end else begin
            // Data byte with no channel status seen: report and halt.
            result_valid       = 1'b1;
            result.event_kind  = KIND_NO_STATUS;
            result.status_byte = b;
            done               = 1'b1;
            halted_next        = 1'b1;
          end
        end
        PH_DATA1: begin
          first_data_next = b;
          if (one_byte_cur) begin
            result_valid               = 1'b1;
            result.event_kind          = KIND_CHANNEL;
            result.status_byte         = current_status;
            result.data_first          = b;
            result.data_count          = COUNT_ONE;
            result.running_status_used = reused;
            done                       = 1'b1;
          end else begin
            phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          result_valid               = 1'b1;
          result.event_kind          = KIND_CHANNEL;
          result.status_byte         = current_status;
          result.data_first          = first_data;
          result.data_second         = b;
          result.data_count          = COUNT_TWO;
          result.running_status_used = reused;
          done                       = 1'b1;
        end
        PH_MTYPE: begin
          meta_type_held_next = b;
          phase_next          = PH_LEN;
        end
        PH_LEN: begin
          len_acc_next = len_push;
          if (!b[7]) begin
            if (len_push == '0) begin
              result_valid       = 1'b1;
              result.event_kind  = (current_status == STATUS_META) ? KIND_META : KIND_SYSEX;
              result.status_byte = current_status;
              result.meta_type   = meta_type_held;
              done               = 1'b1;
            end else begin
              skip_cnt_next = len_push;
              phase_next    = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_cnt_next = skip_dec;
          if (skip_dec == '0) begin
            result_valid          = 1'b1;
            result.event_kind     = (current_status == STATUS_META) ? KIND_META : KIND_SYSEX;
            result.status_byte    = current_status;
            result.meta_type      = meta_type_held;
            result.payload_length = len32[OUT_BITS-1:0];
            done                  = 1'b1;
          end
        end
        default: begin
          phase_next = PH_DELTA;
        end
      endcase

      // A completed event clears everything but running status and the halt.
      if (done) begin
        phase_next          = PH_DELTA;
        delta_acc_next      = '0;
        current_status_next = '0;
        meta_type_held_next = '0;
        len_acc_next        = '0;
        skip_cnt_next       = '0;
        first_data_next     = '0;
        reused_next         = 1'b0;
      end

      // The track ending before the event does gives a truncation result.
      if (item.last_in_track && !result_valid) begin
        delta_next32       = 32'(delta_acc_next);
        result_valid       = 1'b1;
        result             = '0;
        result.event_kind  = KIND_TRUNCATED;
        result.delta_time  = delta_next32[OUT_BITS-1:0];
        result.status_byte = current_status_next;
        result.meta_type   = meta_type_held_next;
      end
    end

    // The last byte of a track returns every register to its reset value.
    if (item.last_in_track) begin
      phase_next          = PH_DELTA;
      delta_acc_next      = '0;
      running_status_next = '0;
      current_status_next = '0;
      meta_type_held_next = '0;
      len_acc_next        = '0;
      skip_cnt_next       = '0;
      first_data_next     = '0;
      reused_next         = 1'b0;
      halted_next         = 1'b0;
    end
  end

  // State registers advance once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      delta_acc      <= '0;
      running_status <= '0;
      current_status <= '0;
      meta_type_held <= '0;
      len_acc        <= '0;
      skip_cnt       <= '0;
      first_data     <= '0;
      reused         <= 1'b0;
      halted         <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      delta_acc      <= delta_acc_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      meta_type_held <= meta_type_held_next;
      len_acc        <= len_acc_next;
      skip_cnt       <= skip_cnt_next;
      first_data     <= first_data_next;
      reused         <= reused_next;
      halted         <= halted_next;
    end
  end

endmodule

// ----- hdl/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser: input register, parser, result register.
//
// The track channel (track_valid, track_stall, track_item) takes one raw byte of a
// track chunk per item, with last_in_track set on the final byte of the track.
// The event channel (event_valid, event_stall, event_item) gives one item for each
// completed event, missing running status error or truncated track.
// A byte taken at one clock edge sits in the input register; the parser works on
// it there and writes any result to the result register when the held byte moves
// on, which waits until the result register is free; event_item shows that register.
// The block takes one byte per cycle, back to back, as long as the result register
// can move on. The byte update is a single pass of shift, compare and decrement
// logic on the phase and VLQ registers, which sets the one-cycle rate.
// When the receiver stalls with a result waiting, the byte held in the input
// register waits too and track_stall rises; the result stays unchanged.
// Reset empties both registers and returns the parser to the start of a track
// with no running status.
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int unsigned VLQ_BITS = 28
) (
  input  logic clk,
  input  logic rst,
  input  logic track_valid,
  output logic track_stall,
  input  in_t  track_item,
  output logic event_valid,
  input  logic event_stall,
  output out_t event_item
);

  logic in_full;
  in_t  in_hold;
  logic advance;
  logic result_valid;
  out_t result;

  // The held byte moves on whenever the result register is free to take a result.
  assign advance     = in_full && (!event_valid || !event_stall);
  assign track_stall = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!track_stall) begin
      in_full <= track_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!track_stall && track_valid) begin
      in_hold <= track_item;
    end
  end

  mtep_parser #(
    .VLQ_BITS(VLQ_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (in_hold),
    .result_valid(result_valid),
    .result      (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance && result_valid) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result_valid) begin
      event_item <= result;
    end
  end

endmodule

// ----- tb/midi_track_event_parser_tb.sv -----
// Self-checking testbench for the MIDI track event parser with its own byte-level parser model.
module midi_track_event_parser_tb;
  import mtep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1350;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;

  // How the result of one table row is decided.
  typedef enum logic [1:0] {
    PREDICTED,
    TYPED_NONE,
    TYPED_EVENT
  } row_check_t;

  typedef struct {
    in_t        item;
    row_check_t check;
    out_t       want;
  } track_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic track_valid = 1'b0;
  logic track_stall;
  in_t  track_item = '0;
  logic event_valid;
  logic event_stall = 1'b0;
  out_t event_item;

  midi_track_event_parser DUT (
    .clk        (clk),
    .rst        (rst),
    .track_valid(track_valid),
    .track_stall(track_stall),
    .track_item (track_item),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_item (event_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stimulus, expectations and bookkeeping.
  track_row_t track_bytes[$];
  out_t       pending_events[$];
  int         next_row = 0;
  int         quiet_cycles = 0;
  int         fail_count = 0;
  int         events_checked = 0;
  int         tracks_made = 0;
  int         kinds_seen[0:7];
  int         send_gap = 0;
  int         recv_gap = 0;
  bit         took_byte;
  bit         took_event;
  bit         fired;
  bit         timed_out = 1'b0;
  out_t       predicted_ev;
  out_t       want_ev;

  // Parser state as the predictor sees it.
  phase_t              parse_phase;
  logic [OUT_BITS-1:0] delta_acc;
  logic [OUT_BITS-1:0] len_acc;
  logic [OUT_BITS-1:0] skip_left;
  logic [7:0]          run_status;
  logic [7:0]          cur_status;
  logic [7:0]          meta_held;
  logic [7:0]          data1_held;
  logic                reused;
  logic                halted;

  // One VLQ step: seven new low bits, high bits shifted out.
  function automatic logic [OUT_BITS-1:0] vlq_shift(input logic [OUT_BITS-1:0] acc,
                                                    input logic [7:0] b);
    return {acc[OUT_BITS-8:0], b[6:0]};
  endfunction

  // Program change and channel pressure carry a single data byte.
  function automatic bit single_data(input logic [7:0] st);
    return ((st & HI_NIBBLE) == PROGRAM_GROUP) || ((st & HI_NIBBLE) == PRESSURE_GROUP);
  endfunction

  function automatic out_t mk_event(input logic [2:0] kind, input logic [OUT_BITS-1:0] delta,
                                    input logic [7:0] st, input logic [7:0] mtype,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [1:0] cnt, input logic [OUT_BITS-1:0] plen,
                                    input logic rs);
    out_t e;
    e.event_kind = kind;
    e.delta_time = delta;
    e.status_byte = st;
    e.meta_type = mtype;
    e.data_first = d1;
    e.data_second = d2;
    e.data_count = cnt;
    e.payload_length = plen;
    e.running_status_used = rs;
    return e;
  endfunction

  function automatic out_t channel_event(input logic [7:0] d1, input logic [7:0] d2,
                                         input logic [1:0] cnt);
    return mk_event(KIND_CHANNEL, delta_acc, cur_status, 8'h00, d1, d2, cnt, '0, reused);
  endfunction

  function automatic out_t system_event(input logic [OUT_BITS-1:0] plen);
    logic [2:0] kind;
    kind = (cur_status == STATUS_META) ? KIND_META : KIND_SYSEX;
    return mk_event(kind, delta_acc, cur_status, meta_held, 8'h00, 8'h00, COUNT_NONE, plen,
                    1'b0);
  endfunction

  // Back to the start of an event; running status and the halt survive.
  task automatic end_event();
    parse_phase = PH_DELTA;
    delta_acc = '0;
    len_acc = '0;
    skip_left = '0;
    cur_status = 8'h00;
    meta_held = 8'h00;
    data1_held = 8'h00;
    reused = 1'b0;
  endtask

  task automatic clear_parser();
    end_event();
    run_status = 8'h00;
    halted = 1'b0;
  endtask

  // Advances the parser state by one track byte and gives the event it completes, if any.
  task automatic parse_track_byte(input in_t it, output bit has_ev, output out_t ev);
    logic [7:0] b;
    b = it.track_byte;
    has_ev = 1'b0;
    ev = '0;
    if (halted) begin
      if (it.last_in_track) clear_parser();
    end else begin
      case (parse_phase)
        PH_DELTA: begin
          delta_acc = vlq_shift(delta_acc, b);
          if (!b[7]) parse_phase = PH_STATUS;
        end
        PH_STATUS: begin
          if ((b & HI_NIBBLE) == SYSTEM_GROUP) begin
            cur_status = b;
            len_acc = '0;
            if (b == STATUS_META) parse_phase = PH_MTYPE;
            else parse_phase = PH_LEN;
          end else if (b[7]) begin
            cur_status = b;
            run_status = b;
            reused = 1'b0;
            parse_phase = PH_DATA1;
          end else if (run_status[7]) begin
            // Running status: this byte is already the first data byte.
            cur_status = run_status;
            reused = 1'b1;
            data1_held = b;
            if (single_data(cur_status)) begin
              has_ev = 1'b1;
              ev = channel_event(b, 8'h00, COUNT_ONE);
              end_event();
            end else begin
              parse_phase = PH_DATA2;
            end
          end else begin
            // A data byte with no status to reuse halts the track.
            has_ev = 1'b1;
            ev = mk_event(KIND_NO_STATUS, delta_acc, b, 8'h00, 8'h00, 8'h00, COUNT_NONE, '0,
                          1'b0);
            end_event();
            halted = 1'b1;
          end
        end
        PH_DATA1: begin
          data1_held = b;
          if (single_data(cur_status)) begin
            has_ev = 1'b1;
            ev = channel_event(b, 8'h00, COUNT_ONE);
            end_event();
          end else begin
            parse_phase = PH_DATA2;
          end
        end
        PH_DATA2: begin
          has_ev = 1'b1;
          ev = channel_event(data1_held, b, COUNT_TWO);
          end_event();
        end
        PH_MTYPE: begin
          meta_held = b;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          len_acc = vlq_shift(len_acc, b);
          if (!b[7]) begin
            if (len_acc == '0) begin
              has_ev = 1'b1;
              ev = system_event('0);
              end_event();
            end else begin
              skip_left = len_acc;
              parse_phase = PH_SKIP;
            end
          end
        end
        default: begin
          if (skip_left != '0) skip_left = skip_left - 1'b1;
          if (skip_left == '0) begin
            has_ev = 1'b1;
            ev = system_event(len_acc);
            end_event();
          end
        end
      endcase
      // The last byte of a track either completes an event or reports truncation.
      if (it.last_in_track) begin
        if (!has_ev) begin
          has_ev = 1'b1;
          ev = mk_event(KIND_TRUNCATED, delta_acc, cur_status, meta_held, 8'h00, 8'h00,
                        COUNT_NONE, '0, 1'b0);
        end
        clear_parser();
      end
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input row_check_t check,
                         input out_t want);
    track_row_t r;
    r.item.track_byte = b;
    r.item.last_in_track = last;
    r.check = check;
    r.want = want;
    track_bytes.push_back(r);
  endtask

  task automatic put_byte(input logic [7:0] b);
    add_row(b, 1'b0, PREDICTED, '0);
  endtask

  // A VLQ in a given number of groups, optionally led by bytes that get shifted out.
  task automatic put_vlq(input logic [OUT_BITS-1:0] v, input int groups, input int junk);
    for (int i = 0; i < junk; i++) put_byte(8'h80 | 8'($urandom));
    for (int i = groups - 1; i >= 0; i--) put_byte({i != 0, v[7 * i +: 7]});
  endtask

  task automatic put_delta();
    int r;
    r = $urandom_range(99);
    if (r < 60) put_vlq(OUT_BITS'($urandom_range(0, 127)), 1, 0);
    else if (r < 85) put_vlq(OUT_BITS'($urandom_range(0, 16383)), 2, 0);
    else if (r < 95) put_vlq(OUT_BITS'($urandom), 4, 0);
    else put_vlq(OUT_BITS'($urandom), 4, $urandom_range(1, 3));
  endtask

  // Length VLQ of a meta or sysex event, then the payload bytes it covers.
  task automatic put_payload();
    int n;
    int groups;
    n = ($urandom_range(9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
    groups = $urandom_range(1, 4);
    put_vlq(OUT_BITS'(n), groups, (groups == 4 && $urandom_range(3) == 0) ?
            $urandom_range(1, 3) : 0);
    repeat (n) put_byte(8'($urandom));
  endtask

  function automatic logic [7:0] data_byte();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
  endfunction

  // One random track: mostly well-formed events, some noise, some cut short.
  task automatic gen_track();
    int start;
    int keep;
    int r;
    logic [7:0] chan;
    logic [7:0] st;
    track_row_t tail;
    start = track_bytes.size();
    chan = 8'h00;
    tracks_made++;
    if ($urandom_range(99) < 10) begin
      // Track opening on a data byte with no status to reuse.
      put_delta();
      put_byte(8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(99);
        if (r < 50) begin
          put_delta();
          if (chan != 8'h00 && $urandom_range(1) == 1) begin
            st = chan;
            put_byte(8'($urandom_range(0, 127)));
          end else begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            chan = st;
            put_byte(st);
            put_byte(data_byte());
          end
          if (!single_data(st)) put_byte(data_byte());
        end else if (r < 70) begin
          put_delta();
          put_byte(STATUS_META);
          put_byte(8'($urandom));
          put_payload();
        end else if (r < 88) begin
          put_delta();
          case ($urandom_range(2))
            0: st = SYSTEM_GROUP;
            1: st = SYSEX_ESCAPE;
            default: st = 8'($urandom_range(8'hF1, 8'hFE));
          endcase
          put_byte(st);
          put_payload();
        end else begin
          repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
        end
      end
    end
    if ($urandom_range(99) < 25) begin
      keep = $urandom_range(1, track_bytes.size() - start);
      while (track_bytes.size() > start + keep) void'(track_bytes.pop_back());
    end
    tail = track_bytes.pop_back();
    tail.item.last_in_track = 1'b1;
    track_bytes.push_back(tail);
  endtask

  // Directed rows: the error path, the largest delta and length VLQs, high data and type bytes, and each event kind.
  task automatic load_directed();
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'h00, 1'b0, TYPED_EVENT,
            mk_event(KIND_NO_STATUS, '0, 8'h00, 8'h00, 8'h00, 8'h00, COUNT_NONE, '0, 1'b0));
    add_row(8'h90, 1'b1, TYPED_NONE, '0);
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'h00, 1'b0, TYPED_EVENT,
            mk_event(KIND_META, '0, 8'hFF, 8'hFF, 8'h00, 8'h00, COUNT_NONE, '0, 1'b0));
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'h9F, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'h80, 1'b0, TYPED_EVENT,
            mk_event(KIND_CHANNEL, '0, 8'h9F, 8'h00, 8'hFF, 8'h80, COUNT_TWO, '0, 1'b0));
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'hD3, 1'b0, PREDICTED, '0);
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'h05, 1'b0, PREDICTED, '0);
    add_row(8'h7F, 1'b0, PREDICTED, '0);
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'hF5, 1'b0, PREDICTED, '0);
    add_row(8'h00, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'h7F, 1'b0, PREDICTED, '0);
    add_row(8'hF0, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'hFF, 1'b0, PREDICTED, '0);
    add_row(8'h7F, 1'b1, TYPED_EVENT,
            mk_event(KIND_TRUNCATED, 28'h0FFFFFFF, 8'hF0, 8'h00, 8'h00, 8'h00, COUNT_NONE, '0,
                     1'b0));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_event(input out_t got, input out_t want);
    if (got.event_kind !== want.event_kind)
      report_mismatch("event_kind", 32'(got.event_kind), 32'(want.event_kind));
    if (got.delta_time !== want.delta_time)
      report_mismatch("delta_time", 32'(got.delta_time), 32'(want.delta_time));
    if (got.status_byte !== want.status_byte)
      report_mismatch("status_byte", 32'(got.status_byte), 32'(want.status_byte));
    if (got.meta_type !== want.meta_type)
      report_mismatch("meta_type", 32'(got.meta_type), 32'(want.meta_type));
    if (got.data_first !== want.data_first)
      report_mismatch("data_first", 32'(got.data_first), 32'(want.data_first));
    if (got.data_second !== want.data_second)
      report_mismatch("data_second", 32'(got.data_second), 32'(want.data_second));
    if (got.data_count !== want.data_count)
      report_mismatch("data_count", 32'(got.data_count), 32'(want.data_count));
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", 32'(got.payload_length), 32'(want.payload_length));
    if (got.running_status_used !== want.running_status_used)
      report_mismatch("running_status_used", 32'(got.running_status_used),
                      32'(want.running_status_used));
  endtask

  // Per-cycle handshakes: take bytes, check events, then drive the next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      took_byte = track_valid && !track_stall;
      took_event = event_valid && !event_stall;
      if (took_byte) begin
        parse_track_byte(track_bytes[next_row].item, fired, predicted_ev);
        case (track_bytes[next_row].check)
          TYPED_EVENT: pending_events.push_back(track_bytes[next_row].want);
          TYPED_NONE: ;
          default: if (fired) pending_events.push_back(predicted_ev);
        endcase
        next_row++;
      end
      if (took_event) begin
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected event, kind", 32'(event_item.event_kind), '0);
        end else begin
          want_ev = pending_events.pop_front();
          compare_event(event_item, want_ev);
          kinds_seen[want_ev.event_kind]++;
          events_checked++;
        end
      end
      quiet_cycles = (took_byte || took_event) ? 0 : quiet_cycles + 1;

      // Idling pattern by quarter of the byte stream.
      case ((next_row * 4) / track_bytes.size())
        0: begin
          send_gap = 0;
          recv_gap = 0;
        end
        1: begin
          send_gap = 49;
          recv_gap = 0;
        end
        2: begin
          send_gap = 0;
          recv_gap = 49;
        end
        default: begin
          send_gap = 10;
          recv_gap = 10;
        end
      endcase

      // A byte on offer stays until taken; only then may the sender idle.
      if (!track_valid || took_byte) begin
        if (next_row < track_bytes.size() && $urandom_range(99) >= send_gap) begin
          track_valid <= 1'b1;
          track_item <= track_bytes[next_row].item;
        end else begin
          track_valid <= 1'b0;
        end
      end
      event_stall <= ($urandom_range(99) < recv_gap);
    end
  end

  // Run control: build stimulus, reset, wait for the stream to drain, give the verdict.
  initial begin
    foreach (kinds_seen[k]) kinds_seen[k] = 0;
    load_directed();
    while (track_bytes.size() < ITEM_TARGET) gen_track();
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (!timed_out && (next_row < track_bytes.size() || pending_events.size() != 0)) begin
      @(negedge clk);
      timed_out = (quiet_cycles >= QUIET_LIMIT);
    end
    if (timed_out) begin
      $display("Timeout: no handshake for %0d cycles, %0d bytes unsent, %0d events missing",
               QUIET_LIMIT, track_bytes.size() - next_row, pending_events.size());
      fail_count++;
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
    end
    $display("Fed %0d track bytes in %0d random tracks plus directed rows, %0d events checked.",
             next_row, tracks_made, events_checked);
    $display("Events: %0d channel, %0d meta, %0d sysex, %0d missing status, %0d truncated.",
             kinds_seen[KIND_CHANNEL], kinds_seen[KIND_META], kinds_seen[KIND_SYSEX],
             kinds_seen[KIND_NO_STATUS], kinds_seen[KIND_TRUNCATED]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mtep_pkg.sv
hdl/mtep_parser.sv
hdl/midi_track_event_parser.sv
tb/midi_track_event_parser_tb.sv
